FILE: design/rwa_pkg.sv
`default_nettype none
package rwa_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 22;
  localparam int AVG_W       = 24;
  localparam int CNT_W       = 7;
  localparam int MAX_WINDOW  = 64;
  localparam int PTR_W       = $clog2(MAX_WINDOW);
  localparam int FRAC_BITS   = 8;
  localparam int DVD_W       = SUM_W + FRAC_BITS;
  localparam int DIV_STEPS   = DVD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(10);
  localparam logic [CNT_W-1:0] WINDOW_MAX   = CNT_W'(MAX_WINDOW);

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } rwa_job_t;

  typedef enum logic {
    F_IDLE,
    F_READ
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  // zero acts as one sample, anything above the store depth saturates
  function automatic logic [CNT_W-1:0] eff_len(input logic [CNT_W-1:0] len);
    logic [CNT_W-1:0] res;
    res = len;
    if (len == '0) res = CNT_W'(1);
    else if (len > WINDOW_MAX) res = WINDOW_MAX;
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: design/rwa_ram.sv
`default_nettype none
module rwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/rwa_front.sv
`default_nettype none
module rwa_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rwa_pkg::CNT_W-1:0]        cfg_window_len,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [rwa_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output rwa_pkg::rwa_job_t                     q_data
);
  import rwa_pkg::*;

  front_state_t state_r, state_nxt;
  logic [CNT_W-1:0]           len_r, len_nxt;
  logic [PTR_W-1:0]           wp_r, wp_nxt;
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic [PTR_W-1:0]           slot_r;
  logic                       full_r;

  logic [CNT_W-1:0]           len_eff;
  logic [PTR_W-1:0]           slot;
  logic [CNT_W-1:0]           slot_inc;
  logic [SAMPLE_W-1:0]        old_sample;
  logic signed [SUM_W-1:0]    old_ext;
  logic signed [SUM_W-1:0]    new_ext;
  logic                       accept;

  assign len_eff  = eff_len(len_r);
  assign slot     = ({1'b0, wp_r} >= len_eff) ? '0 : wp_r;
  assign in_ready = (state_r == F_IDLE) && !q_full;
  assign accept   = in_valid && in_ready;
  assign slot_inc = {1'b0, slot_r} + CNT_W'(1);
  assign old_ext  = full_r ? {{(SUM_W-SAMPLE_W){old_sample[SAMPLE_W-1]}}, old_sample} : '0;
  assign new_ext  = {{(SUM_W-SAMPLE_W){sample_r[SAMPLE_W-1]}}, sample_r};

  // store read is issued on accept, data lands in F_READ
  rwa_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(MAX_WINDOW)
  ) u_store (
    .clk  (clk),
    .we   (state_r == F_READ),
    .waddr(slot_r),
    .wdata(sample_r),
    .raddr(slot),
    .rdata(old_sample)
  );

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    q_push    = 1'b0;
    q_data.sum   = sum_r - old_ext + new_ext;
    q_data.count = full_r ? fill_r : fill_r + CNT_W'(1);
    case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = F_READ;
      end
      F_READ: begin
        q_push    = 1'b1;
        sum_nxt   = q_data.sum;
        fill_nxt  = q_data.count;
        wp_nxt    = (slot_inc >= len_eff) ? '0 : slot_inc[PTR_W-1:0];
        state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
    // a new window length restarts the filter
    if (cfg_we) begin
      len_nxt  = cfg_window_len;
      wp_nxt   = '0;
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      len_r   <= WINDOW_RESET;
      wp_r    <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      wp_r    <= wp_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_sample;
      slot_r   <= slot;
      full_r   <= (fill_r >= len_eff);
    end
  end

endmodule
`default_nettype wire

FILE: design/rwa_queue.sv
`default_nettype none
module rwa_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rwa_pkg::rwa_job_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output rwa_pkg::rwa_job_t      pop_data,
  output logic                   empty
);
  import rwa_pkg::*;

  rwa_job_t            slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_r, wr_nxt;
  logic [QPTR_W-1:0]   rd_r, rd_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = slots_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

FILE: design/rwa_back.sv
`default_nettype none
module rwa_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  output logic                               q_pop,
  input  wire rwa_pkg::rwa_job_t             q_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [rwa_pkg::AVG_W-1:0]   out_average,
  output logic [rwa_pkg::CNT_W-1:0]          out_samples_used
);
  import rwa_pkg::*;

  back_state_t state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    div_r, div_nxt;
  logic                neg_r, neg_nxt;
  logic                ov_r, ov_nxt;
  logic signed [AVG_W-1:0] avg_r, avg_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;

  logic [SUM_W-1:0]    mag;
  logic [CNT_W:0]      rem_sh;
  logic [CNT_W:0]      rem_sub;
  logic                ge;
  logic [AVG_W-1:0]    quo;
  logic                load_out;

  assign mag     = q_data.sum[SUM_W-1] ? SUM_W'(~q_data.sum + SUM_W'(1)) : q_data.sum;
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign ge      = (rem_sh >= {1'b0, div_r});
  assign quo     = dvd_r[AVG_W-1:0];

  assign out_valid        = ov_r;
  assign out_average      = avg_r;
  assign out_samples_used = used_r;

  // restoring divide of |sum|*256 by the count, one quotient bit per cycle
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    neg_nxt   = neg_r;
    avg_nxt   = avg_r;
    used_nxt  = used_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          dvd_nxt   = {mag, FRAC_BITS'(0)};
          rem_nxt   = '0;
          div_nxt   = q_data.count;
          neg_nxt   = q_data.sum[SUM_W-1];
          step_nxt  = '0;
          state_nxt = B_DIV;
        end
      end
      B_DIV: begin
        dvd_nxt  = {dvd_r[DVD_W-2:0], ge};
        rem_nxt  = ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = B_DONE;
      end
      B_DONE: begin
        if (!ov_r || out_ready) begin
          load_out  = 1'b1;
          avg_nxt   = neg_r ? AVG_W'(~quo + AVG_W'(1)) : quo;
          used_nxt  = div_r;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    ov_nxt = load_out || (ov_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    neg_r  <= neg_nxt;
    avg_r  <= avg_nxt;
    used_r <= used_nxt;
  end

endmodule
`default_nettype wire

FILE: design/running_window_average.sv
// channel   direction  handshake             payload
// in        input      in_valid/in_ready     in_sample (s16)
// out       output     out_valid/out_ready   out_average (s24, 8 frac), out_samples_used (u7)
// cfg       input      cfg_we, no wait       cfg_window_len (u7)
//
// front handles each sample with a store read, then a sum update and store write, taking no new
// sample meanwhile; back runs each transaction through load, a 30-step serial divider and unload,
// and takes no new transaction until its result is loaded to out, which waits while out stalls
// a 2-entry queue between front and back lets the front run ahead while out stalls
// rst_n is synchronous; the sample store is not cleared, entries are used only once written
`default_nettype none
module running_window_average (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [rwa_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [rwa_pkg::AVG_W-1:0]       out_average,
  output logic [rwa_pkg::CNT_W-1:0]              out_samples_used,
  input  wire logic                              cfg_we,
  input  wire logic [rwa_pkg::CNT_W-1:0]         cfg_window_len
);
  import rwa_pkg::*;

  rwa_job_t push_data;
  rwa_job_t pop_data;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;

  rwa_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_window_len(cfg_window_len),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_sample     (in_sample),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  rwa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  rwa_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .q_data          (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_average     (out_average),
    .out_samples_used(out_samples_used)
  );

endmodule
`default_nettype wire

FILE: design/rwa_checker.sv
`default_nettype none
module rwa_props (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [rwa_pkg::AVG_W-1:0]  out_average,
  input wire logic [rwa_pkg::CNT_W-1:0]         out_samples_used
);
  import rwa_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average) && $stable(out_samples_used))
    else $error("stalled result changed");

  a_used_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_samples_used != '0)
    else $error("result averaged over zero samples");

  a_used_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_samples_used <= WINDOW_MAX)
    else $error("sample count above store depth");

  // front is busy for the store read right after a transaction
  a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during store read");

endmodule

bind running_window_average rwa_props u_rwa_props (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_average     (out_average),
  .out_samples_used(out_samples_used)
);
`default_nettype wire
